FILE: rtl/ftr_pkg.sv
`timescale 1ns / 1ps
package ftr_pkg;

  // Bitmap geometry
  localparam int MaxSpan   = 256;
  localparam int WordW     = 32;
  localparam int Words     = MaxSpan / WordW;
  localparam int WordAddrW = $clog2(Words);
  localparam int BitW      = $clog2(WordW);
  localparam int OffW      = $clog2(MaxSpan);
  localparam int SpanW     = OffW + 1;

  // Most bits examined per scan cycle
  localparam int ChunkBits = 8;

  // Field widths
  localparam int CmdW      = 2;
  localparam int EntryW    = 16;
  localparam int TileW     = 10;
  localparam int RunLenW   = 9;
  localparam int PreferW   = 8;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 10;
  localparam int BandSpanW = 9;

  localparam logic [TileW-1:0]     BandLowRst  = TileW'(256);
  localparam logic [BandSpanW-1:0] BandSpanRst = BandSpanW'(224);

  typedef enum logic [CmdW-1:0] {
    CmdClear = 2'd0,
    CmdMark  = 2'd1,
    CmdFind  = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBandLow  = 1'd0,
    CfgBandSpan = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [RunLenW-1:0] run_len;
    logic [PreferW-1:0] prefer;
    logic [SpanW-1:0]   span;
  } scan_req_t;

  typedef struct packed {
    logic                valid;
    logic                found;
    logic [PreferW-1:0]  offset;
  } scan_res_t;

  typedef struct packed {
    logic                 re;
    logic [WordAddrW-1:0] addr;
  } rd_req_t;

endpackage

FILE: rtl/ftr_ram.sv
`timescale 1ns / 1ps
module ftr_ram #(
  parameter int Depth = 8,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ftr_scan.sv
`timescale 1ns / 1ps
module ftr_scan import ftr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  scan_req_t        req_i,
  input  logic [WordW-1:0] word_i,
  output rd_req_t          rd_o,
  output scan_res_t        res_o,
  output logic             busy_o
);

  typedef enum logic [1:0] {StIdle, StRead, StScan, StFin} state_e;

  state_e           state_q;
  logic [SpanW-1:0] n_q, span_q, left_q, run_q;
  logic [OffW-1:0]  idx_q, hit_idx_q;
  logic             hit_q;
  scan_res_t        res_q;

  logic [SpanW-1:0] n_in, left_c, run_c, back_c, off_c;
  logic [OffW-1:0]  idx_c, hit_idx_c, pref_c;
  logic             go_c, hit_c, bad_c;

  assign n_in   = SpanW'(req_i.run_len);
  assign bad_c  = (n_in == '0) || (n_in > req_i.span);
  assign pref_c = (SpanW'(req_i.prefer) >= req_i.span) ? '0 : OffW'(req_i.prefer);

  // Walk up to one chunk of the current word; stop at a word boundary or wrap, on a hit, or when no tiles are left
  always_comb begin
    idx_c     = idx_q;
    left_c    = left_q;
    run_c     = run_q;
    hit_c     = 1'b0;
    hit_idx_c = hit_idx_q;
    go_c      = 1'b1;
    for (int k = 0; k < ChunkBits; k++) begin
      if (go_c && !hit_c && (left_c != '0)) begin
        if (word_i[idx_c[BitW-1:0]]) begin
          run_c = '0;
        end else begin
          run_c = run_c + SpanW'(1);
        end
        if (run_c == n_q) begin
          hit_c     = 1'b1;
          hit_idx_c = idx_c;
        end
        left_c = left_c - SpanW'(1);
        if (SpanW'(idx_c) + SpanW'(1) == span_q) begin
          idx_c = '0;
        end else begin
          idx_c = idx_c + OffW'(1);
        end
        go_c = (idx_c[BitW-1:0] != '0);
      end
    end
  end

  // Read the first word in StRead; then fetch the next word as soon as the chunk leaves the current one
  always_comb begin
    rd_o.re   = 1'b0;
    rd_o.addr = idx_q[OffW-1:BitW];
    if (state_q == StRead) begin
      rd_o.re = 1'b1;
    end else if (state_q == StScan && !hit_c && (left_c != '0) && !go_c) begin
      rd_o.re   = 1'b1;
      rd_o.addr = idx_c[OffW-1:BitW];
    end
  end

  // Step back from the last tile of the run, wrapping at the band end
  assign back_c = n_q - SpanW'(1);
  assign off_c  = (SpanW'(hit_idx_q) >= back_c) ? SpanW'(hit_idx_q) - back_c
                                                 : SpanW'(hit_idx_q) + span_q - back_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_q.valid <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      res_q.valid <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            n_q     <= n_in;
            span_q  <= req_i.span;
            left_q  <= req_i.span;
            idx_q   <= pref_c;
            run_q   <= '0;
            hit_q   <= 1'b0;
            state_q <= bad_c ? StFin : StRead;
          end
        end
        StRead: begin
          state_q <= StScan;
        end
        StScan: begin
          idx_q     <= idx_c;
          left_q    <= left_c;
          run_q     <= run_c;
          hit_q     <= hit_c;
          hit_idx_q <= hit_idx_c;
          if (hit_c || (left_c == '0)) begin
            state_q <= StFin;
          end
        end
        StFin: begin
          res_q.valid  <= 1'b1;
          res_q.found  <= hit_q;
          res_q.offset <= hit_q ? PreferW'(off_c) : '0;
          state_q      <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign res_o  = res_q;
  assign busy_o = (state_q != StIdle);

endmodule

FILE: rtl/free_tile_run_finder.sv
`timescale 1ns / 1ps
// Clear and out-of-band mark do not raise busy; an in-band mark holds busy through
// the write-back of the read-modify-write of its bitmap word.
// Find: the scanner passes StRead, then StScan steps, each testing up to 8 bits of
// one word from the single bitmap read port, then StFin, after which done_o pulses.
// A rejected run length (zero or above span) skips to StFin. Results cannot be stalled.
// Reset empties the bitmap at once (per-word valid bits), band_low = 256, span = 224.
module free_tile_run_finder import ftr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [CmdW-1:0]      cmd_i,
  input  logic [EntryW-1:0]    map_entry_i,
  input  logic [RunLenW-1:0]   run_len_i,
  input  logic [PreferW-1:0]   prefer_i,
  output logic                 done_o,
  output logic                 found_o,
  output logic [PreferW-1:0]   start_offset_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i
);

  logic [TileW-1:0]     band_low_q;
  logic [BandSpanW-1:0] band_span_q;
  logic [SpanW-1:0]     span_c;

  logic                 accept, scan_busy, scan_start;
  scan_req_t            scan_req;
  scan_res_t            scan_res;
  rd_req_t              scan_rd;

  logic [TileW-1:0]     tile, diff;
  logic                 in_band;

  logic                 mark_q;
  logic [WordAddrW-1:0] mark_addr_q;
  logic [BitW-1:0]      mark_bit_q;

  logic [Words-1:0]     valid_q;
  logic                 rd_valid_q;
  logic                 ram_re;
  logic [WordAddrW-1:0] ram_raddr;
  logic [WordW-1:0]     ram_rdata, word_c, wdata_c;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_low_q  <= BandLowRst;
      band_span_q <= BandSpanRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgBandLow:  band_low_q  <= cfg_wdata_i[TileW-1:0];
        CfgBandSpan: band_span_q <= cfg_wdata_i[BandSpanW-1:0];
        default: ;
      endcase
    end
  end

  assign span_c = (SpanW'(band_span_q) > SpanW'(MaxSpan)) ? SpanW'(MaxSpan)
                                                          : SpanW'(band_span_q);

  assign accept = start && !busy;
  assign busy   = mark_q || scan_busy;

  // Mark decode
  assign tile    = map_entry_i[TileW-1:0];
  assign diff    = tile - band_low_q;
  assign in_band = (tile >= band_low_q) && (diff < TileW'(span_c));

  assign scan_start       = accept && (cmd_e'(cmd_i) == CmdFind);
  assign scan_req.run_len = run_len_i;
  assign scan_req.prefer  = prefer_i;
  assign scan_req.span    = span_c;

  ftr_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(scan_start),
    .req_i  (scan_req),
    .word_i (word_c),
    .rd_o   (scan_rd),
    .res_o  (scan_res),
    .busy_o (scan_busy)
  );

  // Read port: scanner while it runs, otherwise the mark lookup
  always_comb begin
    if (scan_busy) begin
      ram_re    = scan_rd.re;
      ram_raddr = scan_rd.addr;
    end else begin
      ram_re    = accept && (cmd_e'(cmd_i) == CmdMark) && in_band;
      ram_raddr = diff[OffW-1:BitW];
    end
  end

  // Words never written since the last clear read as empty
  assign word_c  = ram_rdata & {WordW{rd_valid_q}};
  assign wdata_c = word_c | (WordW'(1) << mark_bit_q);

  ftr_ram #(
    .Depth(Words),
    .Width(WordW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mark_q),
    .waddr_i(mark_addr_q),
    .wdata_i(wdata_c),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q     <= 1'b0;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      mark_q <= ram_re && !scan_busy;
      if (ram_re) begin
        rd_valid_q <= valid_q[ram_raddr];
      end
      if (mark_q) begin
        valid_q[mark_addr_q] <= 1'b1;
      end
      if (accept && (cmd_e'(cmd_i) == CmdClear)) begin
        valid_q <= '0;
      end
    end
  end

  // Hold the mark target for the write-back cycle
  always_ff @(posedge clk_i) begin
    if (ram_re && !scan_busy) begin
      mark_addr_q <= diff[OffW-1:BitW];
      mark_bit_q  <= diff[BitW-1:0];
    end
  end

  assign done_o         = scan_res.valid;
  assign found_o        = scan_res.found;
  assign start_offset_o = scan_res.offset;

endmodule
